// ----- hw/rtl/set_assoc_cache_hit_tracker_unit_assert.svh -----
// assertion macros shared by the cache hit tracker modules
`ifndef SET_ASSOC_CACHE_HIT_TRACKER_UNIT_ASSERT_SVH
`define SET_ASSOC_CACHE_HIT_TRACKER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define SCHT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SCHT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    `SCHT_ASSERT(lbl, clk, rst_n, !(cond), msg)
`else
`define SCHT_ASSERT(lbl, clk, rst_n, prop, msg)
`define SCHT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ----- hw/rtl/scht_pkg.sv -----
// shared types and constants of the cache hit tracker
package scht_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int WAYS_WIDTH  = 6;
    localparam logic [WAYS_WIDTH-1:0] WAYS_RESET = 6'd4;

    // remainder bits resolved per divider cycle
    localparam int DIGIT_BITS = 8;

    typedef struct packed {
        logic                   hit;
        logic [COUNT_WIDTH-1:0] hit_total;
        logic [COUNT_WIDTH-1:0] miss_total;
    } result_t;

endpackage

// ----- hw/rtl/scht_ram.sv -----
// generic single-port-write, registered-read ram
module scht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/scht_fifo.sv -----
// short flip-flop queue between the classify front and the lookup back
`include "set_assoc_cache_hit_tracker_unit_assert.svh"

module scht_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    fill_reg, fill_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full      = (fill_reg == NW'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    `SCHT_ASSERT_NEVER(a_push_when_full, clk, rst_n, push && full, "push into a full queue")

endmodule

// ----- hw/rtl/scht_front.sv -----
// front: takes addresses, finds set and victim way with a digit-serial remainder unit
`include "set_assoc_cache_hit_tracker_unit_assert.svh"

module scht_front #(
    parameter int TOTAL_LINES   = 32,
    parameter int ADDRESS_WIDTH = 32
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic [ADDRESS_WIDTH-1:0]                  address,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [scht_pkg::WAYS_WIDTH-1:0]           ways,
    input  logic                                      clear_busy,
    output logic                                      push,
    input  logic                                      queue_full,
    output logic [ADDRESS_WIDTH-1:0]                  push_tag,
    output logic [((TOTAL_LINES > 1) ? $clog2(TOTAL_LINES) : 1)-1:0] push_base,
    output logic [$clog2(TOTAL_LINES + 1)-1:0]        push_ways,
    output logic [((TOTAL_LINES > 1) ? $clog2(TOTAL_LINES) : 1)-1:0] push_victim
);

    localparam int SW        = $clog2(TOTAL_LINES + 1);
    localparam int IW        = (TOTAL_LINES > 1) ? $clog2(TOTAL_LINES) : 1;
    localparam int CNTW      = scht_pkg::COUNT_WIDTH;
    localparam int DIGW      = scht_pkg::DIGIT_BITS;
    localparam int DW_RAW    = (ADDRESS_WIDTH > CNTW) ? ADDRESS_WIDTH : CNTW;
    localparam int DW        = ((DW_RAW + DIGW - 1) / DIGW) * DIGW;
    localparam int DIV_ITERS = DW / DIGW;
    localparam int CW        = (DIV_ITERS > 1) ? $clog2(DIV_ITERS) : 1;
    localparam int LUT_DEPTH = 2 ** scht_pkg::WAYS_WIDTH;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]                      state_reg, state_next;
    logic [scht_pkg::WAYS_WIDTH-1:0] ways_reg, ways_next;
    logic                            stale_reg, stale_next;
    logic [CNTW-1:0]                 acc_cnt_reg, acc_cnt_next;
    logic [SW-1:0]                   acc_mod_reg, acc_mod_next;
    logic [CW-1:0]                   div_cnt_reg, div_cnt_next;
    logic                            phase_cnt_reg, phase_cnt_next;
    logic [ADDRESS_WIDTH-1:0]        tag_reg, tag_next;
    logic [DW-1:0]                   div_num_reg, div_num_next;
    logic [SW-1:0]                   div_d_reg, div_d_next;
    logic [SW-1:0]                   div_rem_reg, div_rem_next;
    logic [SW-1:0]                   set_reg, set_next;

    logic [SW-1:0]   eff_w;
    logic [SW-1:0]   sets_lut [LUT_DEPTH];
    logic [SW-1:0]   sets_w;
    logic [SW-1:0]   div_rem_step;
    logic [SW-1:0]   rem_work;
    logic [SW:0]     trial;
    logic [2*SW-1:0] prod;
    logic [SW:0]     victim_sum;
    logic [SW:0]     mod_inc;

    // set count per ways setting, worked out at elaboration
    for (genvar g = 0; g < LUT_DEPTH; g++)
    begin : g_sets
        localparam int WE_G = (g == 0) ? 1 : ((g > TOTAL_LINES) ? TOTAL_LINES : g);
        assign sets_lut[g] = SW'(TOTAL_LINES / WE_G);
    end

    assign sets_w = sets_lut[ways_reg];

    always_comb
    begin
        priority if (ways_reg == '0)
        begin
            eff_w = SW'(1);
        end
        else if (32'(ways_reg) > TOTAL_LINES)
        begin
            eff_w = SW'(TOTAL_LINES);
        end
        else
        begin
            eff_w = SW'(ways_reg);
        end
    end

    // one remainder digit: restoring steps on the narrow remainder
    always_comb
    begin
        rem_work = div_rem_reg;
        trial    = '0;
        for (int k = 0; k < DIGW; k++)
        begin
            trial = {rem_work, div_num_reg[DW-1-k]};
            if (trial >= {1'b0, div_d_reg})
            begin
                trial = trial - {1'b0, div_d_reg};
            end
            rem_work = trial[SW-1:0];
        end
        div_rem_step = rem_work;
    end

    assign prod       = (2*SW)'(set_reg) * (2*SW)'(eff_w);
    assign victim_sum = (SW+1)'(prod[IW-1:0]) + (SW+1)'(acc_mod_reg);
    assign mod_inc    = {1'b0, acc_mod_reg} + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        ways_next      = ways_reg;
        stale_next     = stale_reg;
        acc_cnt_next   = acc_cnt_reg;
        acc_mod_next   = acc_mod_reg;
        div_cnt_next   = div_cnt_reg;
        phase_cnt_next = phase_cnt_reg;
        tag_next       = tag_reg;
        div_num_next   = div_num_reg;
        div_d_next     = div_d_reg;
        div_rem_next   = div_rem_reg;
        set_next       = set_reg;
        push           = 1'b0;

        if (cfg_valid)
        begin
            ways_next  = ways;
            stale_next = 1'b1;
        end

        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    tag_next       = address;
                    div_rem_next   = '0;
                    div_cnt_next   = '0;
                    phase_cnt_next = stale_reg;
                    // after a ways change or a count wrap the victim phase is recomputed
                    if (stale_reg)
                    begin
                        div_num_next = DW'(acc_cnt_reg);
                        div_d_next   = eff_w;
                    end
                    else
                    begin
                        div_num_next = DW'(address);
                        div_d_next   = sets_w;
                    end
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                div_rem_next = div_rem_step;
                div_num_next = div_num_reg << DIGW;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == CW'(DIV_ITERS - 1))
                begin
                    if (phase_cnt_reg)
                    begin
                        acc_mod_next   = div_rem_step;
                        stale_next     = 1'b0;
                        phase_cnt_next = 1'b0;
                        div_num_next   = DW'(tag_reg);
                        div_d_next     = sets_w;
                        div_rem_next   = '0;
                        div_cnt_next   = '0;
                    end
                    else
                    begin
                        set_next   = div_rem_step;
                        state_next = F_PUSH;
                    end
                end
            end
            F_PUSH:
            begin
                if (!queue_full)
                begin
                    push         = 1'b1;
                    acc_cnt_next = acc_cnt_reg + 1'b1;
                    acc_mod_next = (mod_inc == {1'b0, eff_w}) ? '0 : mod_inc[SW-1:0];
                    if (acc_cnt_reg == '1)
                    begin
                        stale_next = 1'b1;
                    end
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            ways_reg      <= scht_pkg::WAYS_RESET;
            stale_reg     <= 1'b0;
            acc_cnt_reg   <= '0;
            acc_mod_reg   <= '0;
            div_cnt_reg   <= '0;
            phase_cnt_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ways_reg      <= ways_next;
            stale_reg     <= stale_next;
            acc_cnt_reg   <= acc_cnt_next;
            acc_mod_reg   <= acc_mod_next;
            div_cnt_reg   <= div_cnt_next;
            phase_cnt_reg <= phase_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg     <= tag_next;
        div_num_reg <= div_num_next;
        div_d_reg   <= div_d_next;
        div_rem_reg <= div_rem_next;
        set_reg     <= set_next;
    end

    assign in_ready    = (state_reg == F_IDLE) && !clear_busy;
    assign cfg_ready   = 1'b1;
    assign push_tag    = tag_reg;
    assign push_base   = prod[IW-1:0];
    assign push_ways   = eff_w;
    assign push_victim = victim_sum[IW-1:0];

    `SCHT_ASSERT(a_rem_below_divisor, clk, rst_n, (state_reg == F_DIV) |-> (div_rem_reg < div_d_reg), "remainder not below divisor")

endmodule

// ----- hw/rtl/scht_back.sv -----
// back: clears the valid store, scans the ways of a set, fills on miss, keeps totals
`include "set_assoc_cache_hit_tracker_unit_assert.svh"

module scht_back #(
    parameter int TOTAL_LINES   = 32,
    parameter int ADDRESS_WIDTH = 32
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      q_valid,
    output logic                                      q_pop,
    input  logic [ADDRESS_WIDTH-1:0]                  q_tag,
    input  logic [((TOTAL_LINES > 1) ? $clog2(TOTAL_LINES) : 1)-1:0] q_base,
    input  logic [$clog2(TOTAL_LINES + 1)-1:0]        q_ways,
    input  logic [((TOTAL_LINES > 1) ? $clog2(TOTAL_LINES) : 1)-1:0] q_victim,
    output logic                                      clear_busy,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output scht_pkg::result_t                         result
);

    localparam int SW   = $clog2(TOTAL_LINES + 1);
    localparam int IW   = (TOTAL_LINES > 1) ? $clog2(TOTAL_LINES) : 1;
    localparam int CNTW = scht_pkg::COUNT_WIDTH;

    localparam logic [1:0] B_CLEAR  = 2'd0;
    localparam logic [1:0] B_IDLE   = 2'd1;
    localparam logic [1:0] B_SCAN   = 2'd2;
    localparam logic [1:0] B_RESULT = 2'd3;

    logic [1:0]               state_reg, state_next;
    logic [IW-1:0]            clr_cnt_reg, clr_cnt_next;
    logic [SW-1:0]            issue_reg, issue_next;
    logic                     chk_vld_reg, chk_vld_next;
    logic [SW-1:0]            chk_way_reg, chk_way_next;
    logic [CNTW-1:0]          hit_cnt_reg, hit_cnt_next;
    logic [CNTW-1:0]          miss_cnt_reg, miss_cnt_next;
    logic                     out_valid_reg, out_valid_next;
    logic [ADDRESS_WIDTH-1:0] tag_reg, tag_next;
    logic [IW-1:0]            base_reg, base_next;
    logic [SW-1:0]            w_reg, w_next;
    logic [IW-1:0]            victim_reg, victim_next;
    logic                     hit_reg, hit_next;
    scht_pkg::result_t        out_reg, out_next;

    logic [SW:0]              rd_sum;
    logic [IW-1:0]            rd_addr;
    logic [ADDRESS_WIDTH-1:0] tag_rd;
    logic [0:0]               vld_rd;
    logic                     tag_we;
    logic                     vld_we;
    logic [IW-1:0]            vld_waddr;
    logic [0:0]               vld_wdata;
    logic                     found;
    logic                     ended;

    assign rd_sum  = (SW+1)'(base_reg) + (SW+1)'(issue_reg);
    assign rd_addr = rd_sum[IW-1:0];

    // a way is checked in the cycle after its read was issued
    assign found = chk_vld_reg && vld_rd[0] && (tag_rd == tag_reg);
    assign ended = chk_vld_reg && !found
                   && (!vld_rd[0] || (chk_way_reg == (w_reg - 1'b1)));

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        issue_next     = issue_reg;
        chk_vld_next   = chk_vld_reg;
        chk_way_next   = chk_way_reg;
        hit_cnt_next   = hit_cnt_reg;
        miss_cnt_next  = miss_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        tag_next       = tag_reg;
        base_next      = base_reg;
        w_next         = w_reg;
        victim_next    = victim_reg;
        hit_next       = hit_reg;
        out_next       = out_reg;
        q_pop          = 1'b0;
        tag_we         = 1'b0;
        vld_we         = 1'b0;
        vld_waddr      = victim_reg;
        vld_wdata      = 1'b1;

        unique case (state_reg)
            B_CLEAR:
            begin
                vld_we    = 1'b1;
                vld_waddr = clr_cnt_reg;
                vld_wdata = 1'b0;
                if (clr_cnt_reg == IW'(TOTAL_LINES - 1))
                begin
                    state_next = B_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop        = 1'b1;
                    tag_next     = q_tag;
                    base_next    = q_base;
                    w_next       = q_ways;
                    victim_next  = q_victim;
                    issue_next   = '0;
                    chk_vld_next = 1'b0;
                    state_next   = B_SCAN;
                end
            end
            B_SCAN:
            begin
                if (found || ended)
                begin
                    hit_next     = found;
                    chk_vld_next = 1'b0;
                    state_next   = B_RESULT;
                    if (!found)
                    begin
                        tag_we = 1'b1;
                        vld_we = 1'b1;
                    end
                end
                else if (issue_reg < w_reg)
                begin
                    issue_next   = issue_reg + 1'b1;
                    chk_vld_next = 1'b1;
                    chk_way_next = issue_reg;
                end
                else
                begin
                    chk_vld_next = 1'b0;
                end
            end
            B_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    if (hit_reg)
                    begin
                        hit_cnt_next = hit_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        miss_cnt_next = miss_cnt_reg + 1'b1;
                    end
                    out_next.hit        = hit_reg;
                    out_next.hit_total  = hit_reg ? hit_cnt_reg + 1'b1 : hit_cnt_reg;
                    out_next.miss_total = hit_reg ? miss_cnt_reg : miss_cnt_reg + 1'b1;
                    out_valid_next      = 1'b1;
                    state_next          = B_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_cnt_reg   <= '0;
            issue_reg     <= '0;
            chk_vld_reg   <= 1'b0;
            chk_way_reg   <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            issue_reg     <= issue_next;
            chk_vld_reg   <= chk_vld_next;
            chk_way_reg   <= chk_way_next;
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg    <= tag_next;
        base_reg   <= base_next;
        w_reg      <= w_next;
        victim_reg <= victim_next;
        hit_reg    <= hit_next;
        out_reg    <= out_next;
    end

    scht_ram #(
        .WIDTH (ADDRESS_WIDTH),
        .DEPTH (TOTAL_LINES)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (victim_reg),
        .wdata (tag_reg),
        .raddr (rd_addr),
        .rdata (tag_rd)
    );

    scht_ram #(
        .WIDTH (1),
        .DEPTH (TOTAL_LINES)
    ) u_valid_ram (
        .clk   (clk),
        .we    (vld_we),
        .waddr (vld_waddr),
        .wdata (vld_wdata),
        .raddr (rd_addr),
        .rdata (vld_rd)
    );

    assign clear_busy = (state_reg == B_CLEAR);
    assign out_valid  = out_valid_reg;
    assign result     = out_reg;

    `SCHT_ASSERT(a_load_after_result, clk, rst_n, $rose(out_valid_reg) |-> ($past(state_reg) == B_RESULT), "result shown without a finished lookup")
    `SCHT_ASSERT(a_totals_step, clk, rst_n, (state_reg == B_IDLE && $past(state_reg) == B_RESULT) |-> (hit_cnt_reg + miss_cnt_reg == $past(hit_cnt_reg + miss_cnt_reg) + 1), "totals did not advance by one")
    `SCHT_ASSERT(a_check_in_set, clk, rst_n, (state_reg == B_SCAN && chk_vld_reg) |-> (chk_way_reg < w_reg), "checked way outside the set")

endmodule

// ----- hw/rtl/set_assoc_cache_hit_tracker_unit.sv -----
// top level of the set-associative cache hit tracker
//
// Each address beat on in_valid/in_ready is one trace access; each beat on
// out_valid/out_ready returns hit plus the running hit and miss totals after
// that access, in order, one result per address.
// The ways register is written through cfg_valid/cfg_ready/ways; the user
// must write it only while the block is idle, which the block itself does
// not enforce. Ways of zero acts as one, above TOTAL_LINES as TOTAL_LINES.
// The front takes each address through its digit-serial remainder unit,
// with an extra remainder pass on the first access after a ways write or
// a wrap of the access count. The back reads the ways of a set in turn
// on one tag/valid ram read port. A 2-entry queue lets the two overlap;
// throughput is the slower of the two.
// After reset the valid store is cleared one line a cycle, all TOTAL_LINES
// lines, with in_ready low; configuration writes are taken meanwhile.
// A stalled receiver holds the result in the output register; the back then
// waits and the queue and front fill before in_ready drops.
module set_assoc_cache_hit_tracker_unit #(
    parameter int TOTAL_LINES   = 32,
    parameter int ADDRESS_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ADDRESS_WIDTH-1:0]        address,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            hit,
    output logic [scht_pkg::COUNT_WIDTH-1:0] hit_total,
    output logic [scht_pkg::COUNT_WIDTH-1:0] miss_total,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [scht_pkg::WAYS_WIDTH-1:0] ways
);

    localparam int SW = $clog2(TOTAL_LINES + 1);
    localparam int IW = (TOTAL_LINES > 1) ? $clog2(TOTAL_LINES) : 1;
    localparam int EW = ADDRESS_WIDTH + IW + SW + IW;

    logic                     push;
    logic                     queue_full;
    logic [ADDRESS_WIDTH-1:0] push_tag;
    logic [IW-1:0]            push_base;
    logic [SW-1:0]            push_ways;
    logic [IW-1:0]            push_victim;
    logic [EW-1:0]            push_data;
    logic [EW-1:0]            pop_data;
    logic                     q_valid;
    logic                     q_pop;
    logic                     clear_busy;
    scht_pkg::result_t        result;

    scht_front #(
        .TOTAL_LINES   (TOTAL_LINES),
        .ADDRESS_WIDTH (ADDRESS_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .address     (address),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .ways        (ways),
        .clear_busy  (clear_busy),
        .push        (push),
        .queue_full  (queue_full),
        .push_tag    (push_tag),
        .push_base   (push_base),
        .push_ways   (push_ways),
        .push_victim (push_victim)
    );

    assign push_data = {push_tag, push_base, push_ways, push_victim};

    scht_fifo #(
        .WIDTH (EW),
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .not_empty (q_valid)
    );

    scht_back #(
        .TOTAL_LINES   (TOTAL_LINES),
        .ADDRESS_WIDTH (ADDRESS_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_tag      (pop_data[EW-1 -: ADDRESS_WIDTH]),
        .q_base     (pop_data[IW+SW+IW-1 -: IW]),
        .q_ways     (pop_data[SW+IW-1 -: SW]),
        .q_victim   (pop_data[IW-1:0]),
        .clear_busy (clear_busy),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (result)
    );

    assign hit        = result.hit;
    assign hit_total  = result.hit_total;
    assign miss_total = result.miss_total;

endmodule
